### design/ir_pulse_width_transmitter_core_assert.svh
// ----------------------------------------------------------------------------
// IR pulse-width transmitter assertion macros
// Concurrent assertion wrappers that fall away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_TRANSMITTER_CORE_ASSERT_SVH
`define IR_PULSE_WIDTH_TRANSMITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Holds whenever the antecedent holds in the same cycle.
`define IRPTX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irptx assertion failed");

// Holds in the cycle after the antecedent.
`define IRPTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irptx assertion failed");

`else

`define IRPTX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IRPTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/irptx_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter package
// Shared types, command codes, register indexes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package irptx_pkg;

  // Command codes carried from the front end to the encoder.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
  localparam logic [2:0] REG_START_MARK  = 3'd1;
  localparam logic [2:0] REG_ONE_MARK    = 3'd2;
  localparam logic [2:0] REG_ZERO_MARK   = 3'd3;
  localparam logic [2:0] REG_SPACER      = 3'd4;

  localparam int DUR_W  = 20;
  localparam int HALF_W = 8;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 5;

  // Register reset values.
  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 8'd104;
  localparam logic [DUR_W-1:0]  START_MARK_RST  = 20'd19200;
  localparam logic [DUR_W-1:0]  ONE_MARK_RST    = 20'd9600;
  localparam logic [DUR_W-1:0]  ZERO_MARK_RST   = 20'd4800;
  localparam logic [DUR_W-1:0]  SPACER_RST      = 20'd4800;

  // Classified command queued between front end and encoder.
  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] data;
    logic              with_start;
  } cmd_t;

  // Configuration values seen by the encoder.
  typedef struct packed {
    logic [HALF_W-1:0] half_period;
    logic [DUR_W-1:0]  start_mark;
    logic [DUR_W-1:0]  one_mark;
    logic [DUR_W-1:0]  zero_mark;
    logic [DUR_W-1:0]  spacer;
  } cfg_t;

  // A duration of zero counts as one tick.
  function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
    at_least_one = (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

### design/irptx_cfg.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter register file
// APB-style register bank holding carrier and duration settings.
// ----------------------------------------------------------------------------
`default_nettype none

module irptx_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [irptx_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output irptx_pkg::cfg_t                    cfg
);
  import irptx_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= HALF_PERIOD_RST;
      cfg_r.start_mark  <= START_MARK_RST;
      cfg_r.one_mark    <= ONE_MARK_RST;
      cfg_r.zero_mark   <= ZERO_MARK_RST;
      cfg_r.spacer      <= SPACER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HALF_PERIOD: cfg_r.half_period <= pwdata[HALF_W-1:0];
        REG_START_MARK:  cfg_r.start_mark  <= pwdata[DUR_W-1:0];
        REG_ONE_MARK:    cfg_r.one_mark    <= pwdata[DUR_W-1:0];
        REG_ZERO_MARK:   cfg_r.zero_mark   <= pwdata[DUR_W-1:0];
        REG_SPACER:      cfg_r.spacer      <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (reg_idx)
      REG_HALF_PERIOD: prdata = {{(32-HALF_W){1'b0}}, cfg_r.half_period};
      REG_START_MARK:  prdata = {{(32-DUR_W){1'b0}}, cfg_r.start_mark};
      REG_ONE_MARK:    prdata = {{(32-DUR_W){1'b0}}, cfg_r.one_mark};
      REG_ZERO_MARK:   prdata = {{(32-DUR_W){1'b0}}, cfg_r.zero_mark};
      REG_SPACER:      prdata = {{(32-DUR_W){1'b0}}, cfg_r.spacer};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/irptx_front.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter front end
// Accepts input transfers, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module irptx_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [irptx_pkg::DATA_W-1:0]  in_data_byte,
  input  wire logic                          in_with_start,
  output logic                               cmd_valid,
  output irptx_pkg::cmd_t                    cmd,
  input  wire logic                          cmd_pop
);
  import irptx_pkg::*;

  cmd_t       queue_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  // Classify the incoming transfer into a command.
  always_comb begin
    new_cmd.op         = in_action ? OP_SEND : OP_TICK;
    new_cmd.data       = in_data_byte;
    new_cmd.with_start = in_with_start;
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

### design/irptx_back.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter encoder
// Runs marks, spacers and the carrier divider, one command per cycle while the
// output is not stalled, and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module irptx_back #(
  parameter int BITS_PER_WORD = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  wire irptx_pkg::cmd_t cmd,
  output logic                 cmd_pop,
  input  wire irptx_pkg::cfg_t cfg,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_ir_level,
  output logic                 out_busy_res,
  output logic                 out_accepted,
  output logic                 out_byte_done
);
  import irptx_pkg::*;

  localparam int BL_W = $clog2(BITS_PER_WORD + 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MARK   = 2'd1;
  localparam logic [1:0] PH_SPACER = 2'd2;

  logic [1:0]               phase_r,      phase_nxt;
  logic [BITS_PER_WORD-1:0] shift_r,      shift_nxt;
  logic [BL_W-1:0]          bits_left_r,  bits_left_nxt;
  logic                     start_pend_r, start_pend_nxt;
  logic [DUR_W-1:0]         dur_r,        dur_nxt;
  logic [HALF_W-1:0]        car_cnt_r,    car_cnt_nxt;
  logic                     car_lvl_r,    car_lvl_nxt;

  logic                     out_valid_r;
  logic                     ir_level_r,   ir_level_nxt;
  logic                     busy_r,       busy_nxt;
  logic                     accepted_r,   accepted_nxt;
  logic                     done_r,       done_nxt;

  logic                     load_mark;
  logic [DUR_W-1:0]         dur_dec;
  logic [BITS_PER_WORD-1:0] word;

  // The result register frees up when empty or when its transfer completes.
  assign cmd_pop = cmd_valid && (!out_valid_r || !out_stall);
  assign dur_dec = (dur_r != '0) ? dur_r - DUR_W'(1) : dur_r;

  // Fit the data byte to the word width; missing upper bits are zeros.
  assign word = BITS_PER_WORD'(cmd.data);

  // Next encoder state for the command at the head of the queue.
  always_comb begin
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    bits_left_nxt  = bits_left_r;
    start_pend_nxt = start_pend_r;
    dur_nxt        = dur_r;
    car_cnt_nxt    = car_cnt_r;
    car_lvl_nxt    = car_lvl_r;
    accepted_nxt   = 1'b0;
    done_nxt       = 1'b0;
    load_mark      = 1'b0;

    if (cmd.op == OP_SEND) begin
      // A request is taken only when idle; otherwise it is refused.
      if (phase_r == PH_IDLE) begin
        accepted_nxt   = 1'b1;
        shift_nxt      = word;
        bits_left_nxt  = BL_W'(BITS_PER_WORD);
        start_pend_nxt = cmd.with_start;
        load_mark      = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_MARK: begin
          dur_nxt = dur_dec;
          if (dur_dec == '0) begin
            // Last mark tick: output low and spacer starts.
            phase_nxt   = PH_SPACER;
            dur_nxt     = at_least_one(cfg.spacer);
            car_lvl_nxt = 1'b0;
            car_cnt_nxt = '0;
          end else if (car_cnt_r == cfg.half_period) begin
            car_lvl_nxt = ~car_lvl_r;
            car_cnt_nxt = '0;
          end else begin
            car_cnt_nxt = car_cnt_r + HALF_W'(1);
          end
        end
        PH_SPACER: begin
          dur_nxt = dur_dec;
          if (dur_dec == '0) begin
            if (bits_left_r != '0 || start_pend_r) begin
              load_mark = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Load the next mark: a pending start mark first, else the next bit.
    if (load_mark) begin
      if (start_pend_nxt) begin
        start_pend_nxt = 1'b0;
        dur_nxt        = at_least_one(cfg.start_mark);
      end else begin
        dur_nxt   = at_least_one(shift_nxt[0] ? cfg.one_mark : cfg.zero_mark);
        shift_nxt = shift_nxt >> 1;
        if (bits_left_nxt != '0) begin
          bits_left_nxt = bits_left_nxt - BL_W'(1);
        end
      end
      phase_nxt   = PH_MARK;
      car_cnt_nxt = '0;
      car_lvl_nxt = 1'b0;
    end

    ir_level_nxt = (phase_nxt == PH_MARK) ? car_lvl_nxt : 1'b0;
    busy_nxt     = (phase_nxt != PH_IDLE);
  end

  // Encoder state advances once per command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      shift_r      <= '0;
      bits_left_r  <= '0;
      start_pend_r <= 1'b0;
      dur_r        <= '0;
      car_cnt_r    <= '0;
      car_lvl_r    <= 1'b0;
    end else if (cmd_pop) begin
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      bits_left_r  <= bits_left_nxt;
      start_pend_r <= start_pend_nxt;
      dur_r        <= dur_nxt;
      car_cnt_r    <= car_cnt_nxt;
      car_lvl_r    <= car_lvl_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ir_level_r <= ir_level_nxt;
      busy_r     <= busy_nxt;
      accepted_r <= accepted_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ir_level  = ir_level_r;
  assign out_busy_res  = busy_r;
  assign out_accepted  = accepted_r;
  assign out_byte_done = done_r;

endmodule

`default_nettype wire

### design/ir_pulse_width_transmitter_core.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter core
// Encodes words as carrier-modulated marks of three lengths, each followed by
// a low spacer, with an APB-style register port for the timing settings.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  in_*      input      in_valid/in_stall  action, data_byte, with_start
//  out_*     output     out_valid/out_stall ir_level, busy_res, accepted, byte_done
//  APB       input      psel/penable       register writes and reads
//
// One item is taken every cycle while the input is not stalled; each gives one
// result, passing through the two-entry command queue and then the result register.
// The encoder state update does decrement, compare, and mark load together, combinationally.
// Reset is synchronous and active low; no clearing pass is needed.
// An output stall holds the result register and backs up the queue, which
// stalls the input once both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_transmitter_core_assert.svh"

module ir_pulse_width_transmitter_core #(
  parameter int BITS_PER_WORD = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [irptx_pkg::DATA_W-1:0]  in_data_byte,
  input  wire logic                          in_with_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_ir_level,
  output logic                               out_busy_res,
  output logic                               out_accepted,
  output logic                               out_byte_done,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [irptx_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import irptx_pkg::*;

  cmd_t cmd;
  cfg_t cfg;
  logic cmd_valid;
  logic cmd_pop;

  assign pready = 1'b1;

  // Register bank.
  irptx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Front end: accept, classify, queue.
  irptx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_with_start (in_with_start),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Back end: mark and spacer encoder with result register.
  irptx_back #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ir_level  (out_ir_level),
    .out_busy_res  (out_busy_res),
    .out_accepted  (out_accepted),
    .out_byte_done (out_byte_done)
  );

  // A taken request always starts a mark, so the encoder reports busy.
  `IRPTX_ASSERT_IMPL(a_accept_busy, clk, rst_n, out_valid && out_accepted, out_busy_res)

  // The end of a word leaves the encoder idle with the LED off.
  `IRPTX_ASSERT_IMPL(a_done_idle, clk, rst_n, out_valid && out_byte_done,
                     !out_busy_res && !out_ir_level)

  // The LED is only driven while a word is in progress.
  `IRPTX_ASSERT_IMPL(a_led_busy, clk, rst_n, out_valid && out_ir_level, out_busy_res)

  // A command popped from the queue always shows up as a result next cycle.
  `IRPTX_ASSERT_NEXT(a_pop_result, clk, rst_n, cmd_pop, out_valid)

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter core testbench
// Drives ticks and send requests through the input channel, with random
// gaps on both channels. A scoreboard predicts the carrier level, busy,
// accepted and byte-done flags of every item and compares each result
// transfer field by field. Timing registers are rewritten between phases:
// directed corner cases first, then randomized bytes and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import irptx_pkg::*;

  localparam int WORD_BITS = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_ITEMS = 150;
  localparam int PHASE_ITEMS = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_DRAIN = 4;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  typedef enum logic [1:0] {TX_IDLE, TX_MARK, TX_SPACER} tx_phase_t;

  typedef struct packed {
    logic ir_level;
    logic busy;
    logic accepted;
    logic byte_done;
  } ir_levels_t;

  // Predicts the line encoder and checks each result against the oldest
  // expected value.
  class ir_encoder_checker;
    logic [HALF_W-1:0] half_period;
    logic [DUR_W-1:0]  start_len;
    logic [DUR_W-1:0]  one_len;
    logic [DUR_W-1:0]  zero_len;
    logic [DUR_W-1:0]  spacer_len;

    tx_phase_t         phase;
    logic [DATA_W-1:0] shreg;
    logic [3:0]        bits_todo;
    logic              start_due;
    logic [DUR_W-1:0]  remaining;
    logic [HALF_W-1:0] carrier_cnt;
    logic              carrier_lvl;

    ir_levels_t expected_levels[$];
    int errors;
    int taken;
    int refused;
    int bytes_done;
    int checked;

    function new();
      half_period = HALF_PERIOD_RST;
      start_len = START_MARK_RST;
      one_len = ONE_MARK_RST;
      zero_len = ZERO_MARK_RST;
      spacer_len = SPACER_RST;
      phase = TX_IDLE;
      shreg = '0;
      bits_todo = '0;
      start_due = 1'b0;
      remaining = '0;
      carrier_cnt = '0;
      carrier_lvl = 1'b0;
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_HALF_PERIOD: half_period = value[HALF_W-1:0];
        REG_START_MARK:  start_len = value[DUR_W-1:0];
        REG_ONE_MARK:    one_len = value[DUR_W-1:0];
        REG_ZERO_MARK:   zero_len = value[DUR_W-1:0];
        REG_SPACER:      spacer_len = value[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    // A programmed length of zero still lasts one tick.
    function logic [DUR_W-1:0] nonzero_len(logic [DUR_W-1:0] v);
      return (v == '0) ? DUR_W'(1) : v;
    endfunction

    // Start the next mark: the start mark if one is owed, else the next bit.
    function void load_mark();
      logic bit_val;
      if (start_due) begin
        start_due = 1'b0;
        remaining = nonzero_len(start_len);
      end else begin
        bit_val = shreg[0];
        shreg = shreg >> 1;
        if (bits_todo != 0) bits_todo--;
        remaining = nonzero_len(bit_val ? one_len : zero_len);
      end
      phase = TX_MARK;
      carrier_cnt = '0;
      carrier_lvl = 1'b0;
    endfunction

    // Advance the encoder by one accepted input transfer.
    function void take_item(logic action, logic [DATA_W-1:0] data, logic with_start);
      ir_levels_t lv;
      lv = '0;
      if (action == OP_SEND) begin
        if (phase == TX_IDLE) begin
          lv.accepted = 1'b1;
          taken++;
          shreg = data;
          bits_todo = 4'(WORD_BITS);
          start_due = with_start;
          load_mark();
        end else begin
          refused++;
        end
      end else if (phase == TX_MARK) begin
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          phase = TX_SPACER;
          remaining = nonzero_len(spacer_len);
          carrier_lvl = 1'b0;
          carrier_cnt = '0;
        end else if (carrier_cnt == half_period) begin
          carrier_lvl = ~carrier_lvl;
          carrier_cnt = '0;
        end else begin
          carrier_cnt++;
        end
      end else if (phase == TX_SPACER) begin
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          if (bits_todo != 0 || start_due) begin
            load_mark();
          end else begin
            phase = TX_IDLE;
            lv.byte_done = 1'b1;
            bytes_done++;
          end
        end
      end
      lv.ir_level = (phase == TX_MARK) && carrier_lvl;
      lv.busy = (phase != TX_IDLE);
      expected_levels.push_back(lv);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      end
    endfunction

    function void check_levels(ir_levels_t got);
      ir_levels_t want;
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %b",
                 $time, got);
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      compare_field("ir_level", want.ir_level, got.ir_level);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("byte_done", want.byte_done, got.byte_done);
    endfunction

    function bit is_idle();
      return phase == TX_IDLE;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_action;
  logic [DATA_W-1:0] in_data_byte;
  logic in_with_start;
  logic out_valid;
  logic out_stall;
  logic out_ir_level;
  logic out_busy_res;
  logic out_accepted;
  logic out_byte_done;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ir_encoder_checker sb;
  int items;
  int reg_writes;
  int gap_pct;
  int idle_run;
  bit calm_tail;

  ir_pulse_width_transmitter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_data_byte(in_data_byte),
    .in_with_start(in_with_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ir_level(out_ir_level),
    .out_busy_res(out_busy_res),
    .out_accepted(out_accepted),
    .out_byte_done(out_byte_done),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Present one item, hold it until the transfer, then feed the predictor.
  task automatic send_item(logic action, logic [DATA_W-1:0] data, logic with_start);
    if (!calm_tail && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_data_byte <= data;
    in_with_start <= with_start;
    do @(posedge clk); while (in_stall);
    sb.take_item(action, data, with_start);
    items++;
  endtask

  // A tick carries random payload bits, which the block must ignore.
  task automatic tick();
    send_item(OP_TICK, DATA_W'($urandom), 1'($urandom));
  endtask

  // Tick until the current byte is out, with refused requests mixed in.
  task automatic finish_byte(int refuse_pct);
    while (!sb.is_idle()) begin
      if (refuse_pct != 0 && $urandom_range(1, 100) <= refuse_pct)
        send_item(OP_SEND, DATA_W'($urandom), 1'($urandom));
      else
        tick();
    end
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_register(idx, value);
    reg_writes++;
    @(posedge clk);
  endtask

  // Rewrite all timing registers once the block is quiet; unused upper
  // bits get random junk.
  task automatic configure(logic [HALF_W-1:0] half, logic [DUR_W-1:0] start_mark,
                           logic [DUR_W-1:0] one_mark, logic [DUR_W-1:0] zero_mark,
                           logic [DUR_W-1:0] spacer);
    drain();
    write_reg(REG_HALF_PERIOD, {24'($urandom), half});
    write_reg(REG_START_MARK, {12'($urandom), start_mark});
    write_reg(REG_ONE_MARK, {12'($urandom), one_mark});
    write_reg(REG_ZERO_MARK, {12'($urandom), zero_mark});
    write_reg(REG_SPACER, {12'($urandom), spacer});
  endtask

  // Mostly short lengths so many bytes fit; now and then a longer one.
  function automatic logic [DUR_W-1:0] rand_len();
    if ($urandom_range(0, 3) == 0) return DUR_W'($urandom_range(4, 12));
    return DUR_W'($urandom_range(0, 2));
  endfunction

  // Output stalls come in bursts, with a stall rate that changes over time.
  initial begin
    int cycles;
    int stall_pct;
    cycles = 0;
    stall_pct = 10;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 200 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 25;
        endcase
      end
      if (!calm_tail && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_levels({out_ir_level, out_busy_res, out_accepted, out_byte_done});
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_run);
      $display("ir_pulse_width_transmitter_core test failed");
      $finish;
    end
  end

  initial begin
    int random_start;
    int phase_start;
    sb = new();
    items = 0;
    reg_writes = 0;
    gap_pct = 0;
    calm_tail = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= OP_TICK;
    in_data_byte <= '0;
    in_with_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero lengths and a zero half period: carrier toggles every tick.
    configure(8'd0, 20'd0, 20'd2, 20'd1, 20'd0);
    tick();
    tick();
    send_item(OP_SEND, 8'hFF, 1'b1);
    // A request while busy is refused.
    send_item(OP_SEND, 8'hAA, 1'b1);
    finish_byte(0);
    send_item(OP_SEND, 8'h00, 1'b0);
    finish_byte(0);

    // Distinct lengths for every mark kind.
    configure(8'd1, 20'd5, 20'd4, 20'd3, 20'd2);
    send_item(OP_SEND, 8'h5A, 1'b1);
    tick();
    send_item(OP_SEND, 8'hA5, 1'b0);
    finish_byte(0);

    // Every register at its upper limit, with the block left idle.
    configure(8'hFF, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
    tick();
    send_item(OP_TICK, 8'hFF, 1'b1);

    // Slowest carrier over one long start mark; the bit marks are short.
    configure(8'hFF, 20'd520, DUR_MAX, 20'd0, 20'd0);
    send_item(OP_SEND, 8'h00, 1'b1);
    finish_byte(0);

    // Randomized phases: mostly whole bytes, the rest random noise.
    random_start = items;
    phase_start = -PHASE_ITEMS;
    while (items - random_start < RANDOM_ITEMS) begin
      calm_tail = (items - random_start >= RANDOM_ITEMS - CALM_ITEMS);
      if (items - phase_start >= PHASE_ITEMS && !calm_tail) begin
        finish_byte(0);
        configure(HALF_W'(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 3)),
                  rand_len(), rand_len(), rand_len(), rand_len());
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
        phase_start = items;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_item(OP_SEND, DATA_W'($urandom), 1'($urandom));
        finish_byte(5);
        repeat ($urandom_range(0, 3)) tick();
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(1'($urandom), DATA_W'($urandom), 1'($urandom));
      end
    end

    drain();
    $display("Covered %0d items over %0d register writes: %0d sends taken, %0d refused,",
             items, reg_writes, sb.taken, sb.refused);
    $display("%0d bytes completed, %0d results checked.", sb.bytes_done, sb.checked);
    if (sb.errors == 0) begin
      $display("ir_pulse_width_transmitter_core test passed");
    end else begin
      $display("ir_pulse_width_transmitter_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/irptx_pkg.sv
design/irptx_cfg.sv
design/irptx_front.sv
design/irptx_back.sv
design/ir_pulse_width_transmitter_core.sv
tb/sv/tb.sv
